// ----- sv/ipv4dq_pkg.sv -----
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Shared types, constants and helpers for the dotted-quad address parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4dq_pkg;

	localparam int CHAR_W   = 8;
	localparam int ADDR_W   = 32;
	localparam int STATUS_W = 3;
	localparam int ACC_W    = 9;
	localparam int CNT_W    = 3;
	localparam int MAC_W    = 12;

	localparam logic [CHAR_W-1:0] DOT_CHAR = 8'h2E;
	localparam logic [CHAR_W-1:0] DIGIT_LO = 8'h30;
	localparam logic [CHAR_W-1:0] DIGIT_HI = 8'h39;

	localparam logic [ACC_W-1:0] OCTET_MAX = 9'd255;
	localparam logic [ACC_W-1:0] ACC_SAT   = 9'd256;
	localparam logic [MAC_W-1:0] MAC_SAT   = 12'd256;

	localparam logic [CNT_W-1:0] CNT_SAT     = 3'd5;
	localparam logic [CNT_W-1:0] DOT_SAT     = 3'd4;
	localparam logic [CNT_W-1:0] DOTS_NEEDED = 3'd3;
	localparam logic [CNT_W-1:0] RAW_PRIOR   = 3'd3;
	localparam int               RAW_DEPTH   = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_DOTS     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_NONDIGIT = 3'd3,
		ST_RANGE    = 3'd4
	} status_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		status_t           status;
	} result_t;

	function automatic status_t octet_err(input logic has_digit, input logic non_digit,
		input logic [ACC_W-1:0] acc);
		status_t err;
		if (!has_digit && !non_digit) begin
			err = ST_EMPTY;
		end else if (non_digit) begin
			err = ST_NONDIGIT;
		end else if (acc > OCTET_MAX) begin
			err = ST_RANGE;
		end else begin
			err = ST_OK;
		end
		return err;
	endfunction

endpackage

`default_nettype wire

// ----- sv/ipv4dq_char_if.sv -----
// ----------------------------------------------------------------------------
// ipv4dq_char_if
// Character channel: one byte of the string per item, last one marked.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipv4dq_char_if;
	import ipv4dq_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink   (input valid, input char_code, input is_last, output ready);

endinterface

`default_nettype wire

// ----- sv/ipv4dq_addr_if.sv -----
// ----------------------------------------------------------------------------
// ipv4dq_addr_if
// Result channel: parsed address and status, one item per string.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipv4dq_addr_if;
	import ipv4dq_pkg::*;

	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   address;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output address, output status, input ready);
	modport sink   (input valid, input address, input status, output ready);

endinterface

`default_nettype wire

// ----- sv/ipv4dq_scan.sv -----
// ----------------------------------------------------------------------------
// ipv4dq_scan
// Per-string parse state and the combinational character update; forms the
// result for the closing character.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4dq_scan (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      step,
	input  wire logic [ipv4dq_pkg::CHAR_W-1:0] char_code,
	input  wire logic                      is_last,
	output ipv4dq_pkg::result_t            result
);
	import ipv4dq_pkg::*;

	logic [CNT_W-1:0]  char_count_q;
	logic [CHAR_W-1:0] raw_q [RAW_DEPTH];
	logic [CNT_W-1:0]  dot_count_q;
	logic [ACC_W-1:0]  acc_q;
	logic              has_digit_q;
	logic              non_digit_q;
	status_t           first_err_q;
	logic [ADDR_W-1:0] addr_q;

	logic              is_dot;
	logic              is_digit;
	logic [MAC_W-1:0]  mac;
	logic [CNT_W-1:0]  char_count_n;
	logic [CNT_W-1:0]  dot_count_n;
	logic [ACC_W-1:0]  acc_n;
	logic              has_digit_n;
	logic              non_digit_n;
	status_t           first_err_n;
	logic [ADDR_W-1:0] addr_n;
	status_t           err_dot;
	status_t           err_last;
	status_t           first_fin;
	logic [ADDR_W-1:0] addr_fin;

	assign is_dot   = (char_code == DOT_CHAR);
	assign is_digit = (char_code >= DIGIT_LO) && (char_code <= DIGIT_HI);

	// acc * 10 + digit
	assign mac = ({3'b000, acc_q} << 3) + ({3'b000, acc_q} << 1)
		+ {8'h00, char_code[3:0]};

	assign err_dot = octet_err(has_digit_q, non_digit_q, acc_q);

	always_comb begin
		char_count_n = (char_count_q < CNT_SAT) ? char_count_q + 3'd1 : char_count_q;
		dot_count_n  = dot_count_q;
		acc_n        = acc_q;
		has_digit_n  = has_digit_q;
		non_digit_n  = non_digit_q;
		first_err_n  = first_err_q;
		addr_n       = addr_q;
		if (is_dot) begin
			if (dot_count_q < DOT_SAT) begin
				dot_count_n = dot_count_q + 3'd1;
			end
			if (first_err_q == ST_OK) begin
				first_err_n = err_dot;
			end
			addr_n      = {addr_q[ADDR_W-9:0], acc_q[7:0]};
			acc_n       = '0;
			has_digit_n = 1'b0;
			non_digit_n = 1'b0;
		end else if (is_digit) begin
			acc_n       = (mac > MAC_SAT) ? ACC_SAT : mac[ACC_W-1:0];
			has_digit_n = 1'b1;
		end else begin
			non_digit_n = 1'b1;
		end
	end

	// closing octet on the last character
	assign err_last  = octet_err(has_digit_n, non_digit_n, acc_n);
	assign first_fin = (first_err_n == ST_OK) ? err_last : first_err_n;
	assign addr_fin  = {addr_n[ADDR_W-9:0], acc_n[7:0]};

	always_comb begin
		if (char_count_q == RAW_PRIOR) begin
			result.addr   = {raw_q[0], raw_q[1], raw_q[2], char_code};
			result.status = ST_OK;
		end else if (dot_count_n != DOTS_NEEDED) begin
			result.addr   = '0;
			result.status = ST_DOTS;
		end else if (first_fin != ST_OK) begin
			result.addr   = '0;
			result.status = first_fin;
		end else begin
			result.addr   = addr_fin;
			result.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= '0;
			dot_count_q  <= '0;
			acc_q        <= '0;
			has_digit_q  <= 1'b0;
			non_digit_q  <= 1'b0;
			first_err_q  <= ST_OK;
			addr_q       <= '0;
			for (int i = 0; i < RAW_DEPTH; i++) begin
				raw_q[i] <= '0;
			end
		end else if (step) begin
			if (is_last) begin
				char_count_q <= '0;
				dot_count_q  <= '0;
				acc_q        <= '0;
				has_digit_q  <= 1'b0;
				non_digit_q  <= 1'b0;
				first_err_q  <= ST_OK;
				addr_q       <= '0;
				for (int i = 0; i < RAW_DEPTH; i++) begin
					raw_q[i] <= '0;
				end
			end else begin
				char_count_q <= char_count_n;
				dot_count_q  <= dot_count_n;
				acc_q        <= acc_n;
				has_digit_q  <= has_digit_n;
				non_digit_q  <= non_digit_n;
				first_err_q  <= first_err_n;
				addr_q       <= addr_n;
				for (int i = 0; i < RAW_DEPTH; i++) begin
					if (char_count_q == CNT_W'(i)) begin
						raw_q[i] <= char_code;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/ipv4_dotted_quad_parser.sv -----
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser
// Parses a dotted-quad string, one character per item, into a 32-bit
// address and a status; four-character strings are taken as raw octets.
//
//   channel  dir   payload              items
//   chars    sink  char_code, is_last   one per character
//   result   src   address, status      one per string, on the last char
//
// One character per cycle unless a last character meets a stalled result;
// a result passes the input register (last char), then the result register.
// The input register frees itself while the result register is full, so
// characters keep flowing until a second last character meets a stalled
// result. Reset clears all parse state and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_dotted_quad_parser (
	input  wire logic     clk,
	input  wire logic     arst_n,
	ipv4dq_char_if.sink   chars,
	ipv4dq_addr_if.source result
);
	import ipv4dq_pkg::*;

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;

	logic              valid_s2;
	result_t           res_s2;

	logic              out_free;
	logic              adv_s1;
	result_t           res_comb;

	assign out_free    = !valid_s2 || result.ready;
	assign adv_s1      = valid_s1 && (!last_s1 || out_free);
	assign chars.ready = !valid_s1 || adv_s1;

	ipv4dq_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.char_code (char_s1),
		.is_last   (last_s1),
		.result    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign result.valid   = valid_s2;
	assign result.address = res_s2.addr;
	assign result.status  = res_s2.status;

endmodule

`default_nettype wire

// ----- sv/ipv4dq_checker.sv -----
// ----------------------------------------------------------------------------
// ipv4dq_checker
// Port-level checks for the dotted-quad parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4dq_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [ipv4dq_pkg::ADDR_W-1:0]   out_address,
	input wire logic [ipv4dq_pkg::STATUS_W-1:0] out_status
);
	import ipv4dq_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_address) && $stable(out_status))
		else $error("result item changed while stalled");

	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status != ST_OK) |-> (out_address == '0))
		else $error("address not zero on error status");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_status == ST_OK) || (out_status == ST_DOTS)
			|| (out_status == ST_EMPTY) || (out_status == ST_NONDIGIT)
			|| (out_status == ST_RANGE))
		else $error("status code out of range");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("character input stalled with result register empty");

endmodule

bind ipv4_dotted_quad_parser ipv4dq_checker u_ipv4dq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (chars.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_address (result.address),
	.out_status  (result.status)
);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds strings into the dotted-quad parser one character per item: a short
// table of hand-picked strings, then random quads, raw four-byte strings,
// broken quads and noise. Typed rows carry their expected result; a local
// parser predicts the rest; every result item is checked against these in order.
// ----------------------------------------------------------------------------

module testbench;
	import ipv4dq_pkg::*;

	localparam int RANDOM_CHARS = 1600;
	localparam int CALM_CHARS   = 200;
	localparam int HOLD_CYCLES  = 80;
	localparam int N_ROWS       = 26;

	typedef struct {
		int unsigned  len;
		logic [191:0] text;
		bit           typed;
		logic [31:0]  addr;
		status_t      status;
	} quad_row_t;

	quad_row_t quad_rows [N_ROWS] = '{
		'{7,  "1.2.3.4",                     1, 32'h01020304, ST_OK},
		'{15, "255.255.255.255",             1, 32'hFFFFFFFF, ST_OK},
		'{7,  "0.0.0.0",                     1, 32'h00000000, ST_OK},
		'{4,  {8'hFF, 8'h00, 8'h80, 8'h7F},  1, 32'hFF00807F, ST_OK},
		'{4,  "1.2.",                        1, 32'h312E322E, ST_OK},
		'{4,  "1234",                        0, 32'h0,        ST_OK},
		'{5,  "1.2.3",                       1, 32'h0,        ST_DOTS},
		'{9,  "1.2.3.4.5",                   1, 32'h0,        ST_DOTS},
		'{1,  ".",                           1, 32'h0,        ST_DOTS},
		'{5,  ".....",                       1, 32'h0,        ST_DOTS},
		'{5,  "x.1.2",                       1, 32'h0,        ST_DOTS},
		'{1,  "7",                           1, 32'h0,        ST_DOTS},
		'{3,  "...",                         1, 32'h0,        ST_EMPTY},
		'{6,  "1..3.4",                      1, 32'h0,        ST_EMPTY},
		'{6,  "1.2.3.",                      1, 32'h0,        ST_EMPTY},
		'{7,  "1.a.3.4",                     1, 32'h0,        ST_NONDIGIT},
		'{6,  "a.2..4",                      1, 32'h0,        ST_NONDIGIT},
		'{7,  "0.9./.:",                     1, 32'h0,        ST_NONDIGIT},
		'{7,  {"1.2.3.", 8'h80},             1, 32'h0,        ST_NONDIGIT},
		'{7,  {8'h00, ".2.3.4"},             1, 32'h0,        ST_NONDIGIT},
		'{10, "999x.1.1.1",                  1, 32'h0,        ST_NONDIGIT},
		'{9,  "1.2.3.256",                   1, 32'h0,        ST_RANGE},
		'{9,  "1.999.x.4",                   1, 32'h0,        ST_RANGE},
		'{14, "99999999.1.1.1",              1, 32'h0,        ST_RANGE},
		'{17, "00000000001.2.3.4",           0, 32'h0,        ST_OK},
		'{11, "10.200.3.40",                 0, 32'h0,        ST_OK}
	};

	logic clk;
	logic arst_n;

	ipv4dq_char_if chars_bus ();
	ipv4dq_addr_if result_bus ();

	ipv4_dotted_quad_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_bus),
		.result (result_bus)
	);

	// local copy of the parse state
	logic [2:0]  seen_count;
	logic [7:0]  lead_bytes [3];
	logic [2:0]  dot_total;
	logic [8:0]  octet_val;
	logic        octet_digit;
	logic        octet_junk;
	status_t     first_fault;
	logic [31:0] addr_acc;

	result_t     parsed_q [$];
	logic [7:0]  text_q [$];
	int          error_count;
	int          result_count;
	int          holds_asked;
	int          holds_done;
	bit          calm;

	task automatic flag_error(input string what);
		$display("mismatch at result %0d: %s", result_count, what);
		error_count++;
	endtask

	task automatic clear_parse();
		seen_count  = '0;
		lead_bytes  = '{default: '0};
		dot_total   = '0;
		octet_val   = '0;
		octet_digit = 1'b0;
		octet_junk  = 1'b0;
		first_fault = ST_OK;
		addr_acc    = '0;
	endtask

	task automatic finish_octet();
		status_t f;
		if (!octet_digit && !octet_junk) begin
			f = ST_EMPTY;
		end else if (octet_junk) begin
			f = ST_NONDIGIT;
		end else if (octet_val > OCTET_MAX) begin
			f = ST_RANGE;
		end else begin
			f = ST_OK;
		end
		if (first_fault == ST_OK) begin
			first_fault = f;
		end
		addr_acc    = {addr_acc[23:0], octet_val[7:0]};
		octet_val   = '0;
		octet_digit = 1'b0;
		octet_junk  = 1'b0;
	endtask

	task automatic parse_char(input logic [7:0] c, input logic last, output bit done,
		output result_t res);
		logic [2:0]  prior;
		logic [11:0] mac;
		prior = seen_count;
		done  = 1'b0;
		res   = '0;
		if (prior < RAW_PRIOR) begin
			lead_bytes[prior[1:0]] = c;
		end
		if (seen_count < CNT_SAT) begin
			seen_count++;
		end
		if (c == DOT_CHAR) begin
			if (dot_total < DOT_SAT) begin
				dot_total++;
			end
			finish_octet();
		end else if (c >= DIGIT_LO && c <= DIGIT_HI) begin
			mac         = octet_val * 12'd10 + 12'(c - DIGIT_LO);
			octet_val   = (mac > MAC_SAT) ? ACC_SAT : mac[8:0];
			octet_digit = 1'b1;
		end else begin
			octet_junk = 1'b1;
		end
		if (last) begin
			finish_octet();
			done = 1'b1;
			if (prior == RAW_PRIOR) begin
				res.addr   = {lead_bytes[0], lead_bytes[1], lead_bytes[2], c};
				res.status = ST_OK;
			end else if (dot_total != DOTS_NEEDED) begin
				res.addr   = '0;
				res.status = ST_DOTS;
			end else if (first_fault != ST_OK) begin
				res.addr   = '0;
				res.status = first_fault;
			end else begin
				res.addr   = addr_acc;
				res.status = ST_OK;
			end
			clear_parse();
		end
	endtask

	task automatic send_char(input logic [7:0] c, input logic last, input bit typed,
		input result_t typed_res);
		bit      done;
		result_t res;
		chars_bus.valid     <= 1'b1;
		chars_bus.char_code <= c;
		chars_bus.is_last   <= last;
		do @(posedge clk); while (!chars_bus.ready);
		parse_char(c, last, done, res);
		if (done) begin
			parsed_q.insert(parsed_q.size(), typed ? typed_res : res);
		end
	endtask

	task automatic idle_sender();
		chars_bus.valid <= 1'b0;
		repeat ($urandom_range(1, 10)) @(posedge clk);
	endtask

	task automatic drain_results();
		chars_bus.valid <= 1'b0;
		@(posedge clk);
		while (parsed_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 3))
			0: begin
				return DOT_CHAR;
			end
			1: begin
				return 8'($urandom_range(DIGIT_LO, DIGIT_HI));
			end
			default: begin
				return 8'($urandom_range(0, 255));
			end
		endcase
	endfunction

	task automatic push_decimal(input int unsigned v);
		logic [7:0] digs [$];
		repeat (($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0) begin
			text_q.insert(text_q.size(), DIGIT_LO);
		end
		do begin
			digs.push_front(DIGIT_LO + 8'(v % 10));
			v = v / 10;
		end while (v != 0);
		foreach (digs[k]) begin
			text_q.insert(text_q.size(), digs[k]);
		end
	endtask

	// mostly clean quads, some with one byte broken, plus raw and noise strings
	task automatic build_text();
		int unsigned kind;
		int unsigned pos;
		text_q.delete();
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			repeat (4) text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
		end else if (kind < 22) begin
			repeat ($urandom_range(1, 10)) text_q.insert(text_q.size(), noise_byte());
		end else begin
			for (int k = 0; k < 4; k++) begin
				if (k != 0) begin
					text_q.insert(text_q.size(), DOT_CHAR);
				end
				case ($urandom_range(0, 19))
					0: begin
						push_decimal(0);
					end
					1: begin
						push_decimal(255);
					end
					2: begin
						push_decimal($urandom_range(256, 999));
					end
					default: begin
						push_decimal($urandom_range(0, 255));
					end
				endcase
			end
			if (kind >= 75) begin
				pos = $urandom_range(0, text_q.size() - 1);
				case ($urandom_range(0, 3))
					0: begin
						text_q[pos] = noise_byte();
					end
					1: begin
						text_q.delete(pos);
					end
					2: begin
						text_q.insert(pos, noise_byte());
					end
					default: begin
						text_q.insert(text_q.size(), noise_byte());
					end
				endcase
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		result_bus.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (holds_done < holds_asked) begin
				result_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				result_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				result_bus.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_result
		result_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (parsed_q.size() == 0) begin
				flag_error($sformatf("unexpected item addr %h status %0d",
					result_bus.address, result_bus.status));
			end else begin
				want = parsed_q.pop_front();
				if (result_bus.address !== want.addr) begin
					flag_error($sformatf("address %h, wanted %h", result_bus.address,
						want.addr));
				end
				if (result_bus.status !== want.status) begin
					flag_error($sformatf("status %0d, wanted %0d", result_bus.status,
						want.status));
				end
			end
			result_count++;
		end
	end

	initial begin
		int        random_chars;
		int        strings_done;
		bit        gappy;
		result_t   row_res;
		quad_row_t row;

		error_count  = 0;
		result_count = 0;
		holds_asked  = 0;
		holds_done   = 0;
		calm         = 1'b0;
		random_chars = 0;
		strings_done = 0;
		clear_parse();

		arst_n              <= 1'b0;
		chars_bus.valid     <= 1'b0;
		chars_bus.char_code <= '0;
		chars_bus.is_last   <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (quad_rows[r]) begin
			row            = quad_rows[r];
			row_res.addr   = row.addr;
			row_res.status = row.status;
			for (int i = 0; i < row.len; i++) begin
				send_char(row.text[8 * (row.len - 1 - i) +: 8], i == row.len - 1, row.typed,
					row_res);
			end
		end
		drain_results();

		while (random_chars < RANDOM_CHARS) begin
			strings_done++;
			calm = (random_chars >= RANDOM_CHARS - CALM_CHARS);
			// long result stall while characters keep coming
			if (strings_done == 40) begin
				holds_asked++;
			end
			if (!calm && strings_done % 60 == 0) begin
				drain_results();
			end
			gappy = !calm && !(strings_done >= 40 && strings_done < 55) &&
				$urandom_range(0, 1) == 0;
			build_text();
			foreach (text_q[k]) begin
				if (gappy && $urandom_range(0, 3) == 0) begin
					idle_sender();
				end
				send_char(text_q[k], k == text_q.size() - 1, 1'b0, '0);
				random_chars++;
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
